// ----- design/ste_pkg.sv -----
// shared types, constants and row functions for the stabilizer tableau engine
package ste_pkg;

  localparam int MAX_Q = 64;
  localparam int QW    = $clog2(MAX_Q);
  localparam int NW    = QW + 1;
  localparam int RW    = QW + 1;
  localparam int CW    = RW + 1;
  localparam int ROWS  = 2 * MAX_Q;

  localparam logic [63:0] GEN_INC = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] GEN_M1  = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] GEN_M2  = 64'h94D049BB133111EB;

  typedef enum logic [2:0] {
    CMD_INIT   = 3'd0,
    CMD_H      = 3'd1,
    CMD_S      = 3'd2,
    CMD_X      = 3'd3,
    CMD_Z      = 3'd4,
    CMD_CNOT   = 3'd5,
    CMD_MEAS   = 3'd6,
    CMD_RESEED = 3'd7
  } cmd_t;

  typedef enum logic {
    CFG_QUBIT_COUNT = 1'b0,
    CFG_RANDOM_SEED = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_GATE, S_PSRCH, S_RAND, S_DET,
    S_G0, S_G1, S_G2, S_G3, S_G4, S_G5, S_G6, S_HOLD
  } st_t;

  typedef struct packed {
    logic [MAX_Q-1:0] x;
    logic [MAX_Q-1:0] z;
    logic             ph;
  } row_t;

  typedef struct packed {
    logic odd;
    row_t row;
  } rs_res_t;

  // identity row: destabilisers carry x, stabilisers carry z
  function automatic row_t reset_row(input logic [RW-1:0] r);
    row_t v;
    v = '0;
    if (r[RW-1]) v.z[r[QW-1:0]] = 1'b1;
    else         v.x[r[QW-1:0]] = 1'b1;
    return v;
  endfunction

  function automatic logic [MAX_Q-1:0] col_mask(input logic [NW-1:0] n);
    logic [MAX_Q-1:0] m;
    if (n >= NW'(MAX_Q)) m = '1;
    else                 m = (MAX_Q'(1) << n) - MAX_Q'(1);
    return m;
  endfunction

  // dst := src * dst over the active columns, odd flags an odd phase sum
  function automatic rs_res_t rowsum(input row_t d, input row_t s,
                                     input logic [MAX_Q-1:0] m);
    logic [MAX_Q-1:0] both, onlyx, onlyz, c1, c3, lo, hi;
    logic [1:0]       sum;
    rs_res_t          res;
    both  = s.x & s.z;
    onlyx = s.x & ~s.z;
    onlyz = s.z & ~s.x;
    c1 = (both & d.z & ~d.x) | (onlyx & d.z & d.x) | (onlyz & d.x & ~d.z);
    c3 = (both & d.x & ~d.z) | (onlyx & d.z & ~d.x) | (onlyz & d.x & d.z);
    lo = (c1 | c3) & m;
    hi = c3 & m;
    sum = 2'($countones(lo)) + {1'($countones(hi)), 1'b0} + {d.ph ^ s.ph, 1'b0};
    res.odd    = sum[0];
    res.row.ph = sum[1];
    res.row.x  = d.x ^ (s.x & m);
    res.row.z  = d.z ^ (s.z & m);
    return res;
  endfunction

endpackage

// ----- design/ste_if.sv -----
// command and result channel interfaces
interface ste_in_if;
  import ste_pkg::*;
  logic          valid;
  logic          ready;
  logic [2:0]    cmd;
  logic [QW-1:0] qubit_a;
  logic [QW-1:0] qubit_b;
  modport source (output valid, cmd, qubit_a, qubit_b, input ready);
  modport sink   (input valid, cmd, qubit_a, qubit_b, output ready);
endinterface

interface ste_out_if;
  logic valid;
  logic ready;
  logic outcome;
  logic was_random;
  logic phase_error;
  modport source (output valid, outcome, was_random, phase_error, input ready);
  modport sink   (input valid, outcome, was_random, phase_error, output ready);
endinterface

// ----- design/stabilizer_tableau_engine.sv -----
// stabilizer tableau engine top level: row walker, rowsum unit, generator
//
//  channel  dir  handshake          payload
//  in_ch    in   valid/ready        cmd, qubit_a, qubit_b
//  out_ch   out  valid/ready        outcome, was_random, phase_error
//  cfg      in   cfg_we             cfg_idx, cfg_wdata
//
// gates walk every active row, one tableau row read and written per cycle
// measurement: pivot search over the stabilisers, then rowsum over all rows
//   and the generator (random), or a rowsum into scratch (deterministic)
// init and reseed finish while idle; results pass a holding state into the
//   output register, so a waiting result stalls only the next result
// synchronous active-low reset; the tableau rows reset through valid bits
module stabilizer_tableau_engine (
  input  logic                  clk,
  input  logic                  rst_n,
  ste_in_if.sink                in_ch,
  ste_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic                  cfg_idx,
  input  logic [63:0]           cfg_wdata
);
  import ste_pkg::*;

  st_t state_r, state_nxt;

  // tableau memory, scratch row lives in acc_r
  row_t              mem [ROWS];
  logic [ROWS-1:0]   vld_r;
  row_t              a_dat_r, b_dat_r;
  logic              a_vld_r, b_vld_r;

  logic [NW-1:0]     qc_r;
  logic [63:0]       seed_r;
  logic [63:0]       gen_r, gen_nxt;

  cmd_t              cmd_r;
  logic [QW-1:0]     qa_r, qb_r;

  // walk pipeline
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              p1_vld_r, p1_vld_nxt;
  logic [RW-1:0]     p1_row_r, p1_rowb_r;

  logic [QW-1:0]     piv_r, piv_nxt;
  row_t              piv_row_r, piv_row_nxt;
  row_t              acc_r, acc_nxt;

  // generator datapath, one shared 32x32 multiplier
  logic [63:0]       t_r, t_nxt, prod_r, prod_nxt;
  logic [31:0]       hi_r, hi_nxt;
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       mul_p;
  logic [63:0]       gsum, wfull;

  logic              res_o_r, res_r_r, res_e_r;
  logic              res_o_nxt, res_r_nxt, res_e_nxt;
  logic              out_vld_r, out_o_r, out_r_r, out_e_r;

  logic [NW-1:0]     n_eff;
  logic [MAX_Q-1:0]  mask;
  logic [CW-1:0]     walk_lim;
  logic              issue, walk_done, in_fire, out_free;
  logic [RW-1:0]     rd_row_a, rd_row_b;
  row_t              ra, rb, gate_row;
  row_t              rs_dst, rs_src;
  rs_res_t           rs;
  logic              do_rs, a_ok, b_ok, gbit;

  logic              mem_we;
  logic [RW-1:0]     mem_wa;
  row_t              mem_wd;

  assign n_eff    = (qc_r > NW'(MAX_Q)) ? NW'(MAX_Q) : qc_r;
  assign mask     = col_mask(n_eff);
  assign in_fire  = in_ch.valid & in_ch.ready;
  assign out_free = ~out_vld_r | out_ch.ready;
  assign a_ok     = {1'b0, in_ch.qubit_a} < n_eff;
  assign b_ok     = {1'b0, in_ch.qubit_b} < n_eff;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_vld_r;
  assign out_ch.outcome     = out_o_r;
  assign out_ch.was_random  = out_r_r;
  assign out_ch.phase_error = out_e_r;

  // invalid rows read as their identity value
  assign ra = a_vld_r ? a_dat_r : reset_row(p1_row_r);
  assign rb = b_vld_r ? b_dat_r : reset_row(p1_rowb_r);

  // walk limits and read addresses
  always_comb begin
    walk_lim = {1'b0, n_eff};
    if (state_r == S_GATE || state_r == S_RAND) walk_lim = {n_eff, 1'b0};
    issue     = cnt_r < walk_lim;
    walk_done = ~issue & ~p1_vld_r;
    rd_row_b  = {1'b1, cnt_r[QW-1:0]};
    unique case (state_r)
      S_PSRCH: rd_row_a = {1'b1, cnt_r[QW-1:0]};
      S_DET:   rd_row_a = {1'b0, cnt_r[QW-1:0]};
      default: begin
        if (cnt_r < {1'b0, n_eff}) rd_row_a = cnt_r[RW-1:0];
        else rd_row_a = RW'(cnt_r - {1'b0, n_eff} + CW'(MAX_Q));
      end
    endcase
  end

  // single-qubit gates and cnot on one row
  always_comb begin
    logic xa, za, xb, zb;
    xa = ra.x[qa_r];
    za = ra.z[qa_r];
    xb = ra.x[qb_r];
    zb = ra.z[qb_r];
    gate_row = ra;
    unique case (cmd_r)
      CMD_H: begin
        gate_row.ph       = ra.ph ^ (xa & za);
        gate_row.x[qa_r]  = za;
        gate_row.z[qa_r]  = xa;
      end
      CMD_S: begin
        gate_row.ph       = ra.ph ^ (xa & za);
        gate_row.z[qa_r]  = za ^ xa;
      end
      CMD_X: gate_row.ph = ra.ph ^ za;
      CMD_Z: gate_row.ph = ra.ph ^ xa;
      CMD_CNOT: begin
        gate_row.ph       = ra.ph ^ (xa & zb & ~(xb ^ za));
        gate_row.x[qb_r]  = xb ^ xa;
        gate_row.z[qa_r]  = za ^ zb;
      end
      default: gate_row = ra;
    endcase
  end

  // shared rowsum unit: pivot into row, or stabiliser into scratch
  assign rs_dst = (state_r == S_DET) ? acc_r : ra;
  assign rs_src = (state_r == S_DET) ? rb : piv_row_r;
  assign rs     = rowsum(rs_dst, rs_src, mask);
  assign do_rs  = (state_r == S_DET) ? ra.x[qa_r]
                : ((p1_row_r != {1'b1, piv_r}) & ra.x[qa_r]);

  // shared multiplier operand select
  always_comb begin
    mul_a = t_r[31:0];
    mul_b = GEN_M1[31:0];
    unique case (state_r)
      S_G2:    mul_a = t_r[63:32];
      S_G3:    mul_b = GEN_M1[63:32];
      S_G5:    mul_b = GEN_M2[31:0];
      default: ;
    endcase
  end
  assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};
  assign gsum  = gen_r + GEN_INC;
  assign wfull = {hi_r, prod_r[31:0]};
  assign gbit  = prod_r[0] ^ prod_r[31];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (cmd_t'(in_ch.cmd))
            CMD_H, CMD_S, CMD_X, CMD_Z: if (a_ok) state_nxt = S_GATE;
            CMD_CNOT:
              if (a_ok && b_ok && in_ch.qubit_a != in_ch.qubit_b) state_nxt = S_GATE;
            CMD_MEAS: if (a_ok) state_nxt = S_PSRCH;
            default: ;
          endcase
        end
      end
      S_GATE: if (walk_done) state_nxt = S_IDLE;
      S_PSRCH: begin
        priority if (p1_vld_r && ra.x[qa_r]) state_nxt = S_RAND;
        else if (walk_done) state_nxt = S_DET;
        else ;
      end
      S_RAND, S_DET: begin
        priority if (p1_vld_r && do_rs && rs.odd) state_nxt = S_HOLD;
        else if (walk_done) state_nxt = (state_r == S_RAND) ? S_G0 : S_HOLD;
        else ;
      end
      S_G0: state_nxt = S_G1;
      S_G1: state_nxt = S_G2;
      S_G2: state_nxt = S_G3;
      S_G3: state_nxt = S_G4;
      S_G4: state_nxt = S_G5;
      S_G5: state_nxt = S_G6;
      S_G6: state_nxt = S_HOLD;
      S_HOLD: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory write control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = p1_row_r;
    mem_wd = gate_row;
    unique case (state_r)
      S_GATE: mem_we = p1_vld_r;
      S_RAND: begin
        mem_we = p1_vld_r & do_rs & ~rs.odd;
        mem_wd = rs.row;
      end
      S_G0: begin
        mem_we = 1'b1;
        mem_wa = {1'b0, piv_r};
        mem_wd = piv_row_r;
      end
      S_G6: begin
        mem_we        = 1'b1;
        mem_wa        = {1'b1, piv_r};
        mem_wd        = '0;
        mem_wd.z[qa_r] = 1'b1;
        mem_wd.ph     = gbit;
      end
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    cnt_nxt     = issue ? cnt_r + CW'(1) : cnt_r;
    p1_vld_nxt  = issue & (state_r != S_IDLE) & (state_r != S_HOLD);
    piv_nxt     = piv_r;
    piv_row_nxt = piv_row_r;
    acc_nxt     = acc_r;
    gen_nxt     = gen_r;
    t_nxt       = t_r;
    prod_nxt    = prod_r;
    hi_nxt      = hi_r;
    res_o_nxt   = res_o_r;
    res_r_nxt   = res_r_r;
    res_e_nxt   = res_e_r;
    if (state_nxt != state_r) begin
      cnt_nxt    = '0;
      p1_vld_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: if (in_fire && cmd_t'(in_ch.cmd) == CMD_RESEED) gen_nxt = seed_r;
      S_PSRCH: begin
        if (p1_vld_r && ra.x[qa_r]) begin
          piv_nxt     = p1_row_r[QW-1:0];
          piv_row_nxt = ra;
        end
        acc_nxt = '0;
      end
      S_RAND, S_DET: begin
        res_o_nxt = (state_r == S_DET) ? acc_r.ph : 1'b0;
        res_r_nxt = (state_r == S_RAND);
        res_e_nxt = 1'b0;
        if (p1_vld_r && do_rs) begin
          if (rs.odd) begin
            res_o_nxt = 1'b0;
            res_e_nxt = 1'b1;
          end else if (state_r == S_DET) begin
            acc_nxt = rs.row;
          end
        end
      end
      S_G0: begin
        gen_nxt = gsum;
        t_nxt   = gsum ^ (gsum >> 30);
      end
      S_G1: prod_nxt = mul_p;
      S_G2: hi_nxt = prod_r[63:32] + mul_p[31:0];
      S_G3: hi_nxt = hi_r + mul_p[31:0];
      S_G4: t_nxt = wfull ^ (wfull >> 27);
      S_G5: prod_nxt = mul_p;
      S_G6: begin
        res_o_nxt = gbit;
        res_r_nxt = 1'b1;
        res_e_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  // memory with registered reads on two ports
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    a_dat_r <= mem[rd_row_a];
    b_dat_r <= mem[rd_row_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      vld_r     <= '0;
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      p1_vld_r  <= 1'b0;
      cnt_r     <= '0;
      gen_r     <= '0;
      qc_r      <= NW'(MAX_Q);
      seed_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      p1_vld_r <= p1_vld_nxt;
      cnt_r    <= cnt_nxt;
      gen_r    <= gen_nxt;
      a_vld_r  <= vld_r[rd_row_a];
      b_vld_r  <= vld_r[rd_row_b];
      // init resets the whole tableau through the valid bits
      if (state_r == S_IDLE && in_fire && cmd_t'(in_ch.cmd) == CMD_INIT) vld_r <= '0;
      else if (mem_we) vld_r[mem_wa] <= 1'b1;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_idx))
          CFG_QUBIT_COUNT: qc_r <= cfg_wdata[NW-1:0];
          CFG_RANDOM_SEED: seed_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == S_HOLD && out_free) out_vld_r <= 1'b1;
      else if (out_ch.ready) out_vld_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    p1_row_r  <= rd_row_a;
    p1_rowb_r <= rd_row_b;
    piv_r     <= piv_nxt;
    piv_row_r <= piv_row_nxt;
    acc_r     <= acc_nxt;
    t_r       <= t_nxt;
    prod_r    <= prod_nxt;
    hi_r      <= hi_nxt;
    res_o_r   <= res_o_nxt;
    res_r_r   <= res_r_nxt;
    res_e_r   <= res_e_nxt;
    if (in_fire) begin
      cmd_r <= cmd_t'(in_ch.cmd);
      qa_r  <= in_ch.qubit_a;
      qb_r  <= in_ch.qubit_b;
    end
    if (state_r == S_HOLD && out_free) begin
      out_o_r <= res_o_r;
      out_r_r <= res_r_r;
      out_e_r <= res_e_r;
    end
  end

  // tableau is never written while idle
  a_idle_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !mem_we) else $error("tableau write while idle");

  // a held result waits for the output register to free up
  a_hold_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HOLD && !out_free) |=> state_r == S_HOLD)
    else $error("result left hold early");

  // a phase error never comes with a nonzero outcome
  a_err_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_e_r) |-> !out_o_r) else $error("outcome set on phase error");

  // the generator advances only at the start of its sequence
  a_gen_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_G0 && state_r != S_IDLE) |=> $stable(gen_r))
    else $error("generator moved outside its sequence");

endmodule
